// ===== rtl/drf_pkg.sv =====
// drf_pkg: widths, register indexes, mode and cause codes and the result type
// of the delimiter receive framer
// no dependencies
package drf_pkg;

    localparam int MAX_BUFFER = 4096;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 13;
    localparam int MODE_W = 2;
    localparam int CAUSE_W = 2;
    localparam int REG_IDX_W = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [REG_IDX_W-1:0] REG_NOTIFY_MODE    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_DELIMITER_BYTE = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_BUFFER_SIZE    = 2'd2;

    localparam logic [MODE_W-1:0] MODE_CHUNK     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FULL      = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DELIMITER = 2'd2;

    localparam logic [CAUSE_W-1:0] CAUSE_DELIMITER = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_FULL      = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_CHUNK     = 2'd2;

    localparam logic [LEN_W-1:0] RESET_BUFFER_SIZE = LEN_W'(MAX_BUFFER);
    localparam logic [BYTE_W-1:0] RESET_DELIMITER  = 8'd10;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic               kept;
        logic               frame_end;
        logic [LEN_W-1:0]   frame_length;
        logic [CAUSE_W-1:0] end_cause;
    } t_result;

endpackage

// ===== rtl/drf_ifs.sv =====
// drf_ifs: valid/ready channels of the framer: received bytes, results and
// register writes
// depends on drf_pkg
interface drf_byte_if import drf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              chunk_end;

    modport source (output valid, output data_byte, output chunk_end, input ready);
    modport sink (input valid, input data_byte, input chunk_end, output ready);
endinterface

interface drf_res_if import drf_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [BYTE_W-1:0]  out_byte;
    logic               kept;
    logic               frame_end;
    logic [LEN_W-1:0]   frame_length;
    logic [CAUSE_W-1:0] end_cause;

    modport source (output valid, output out_byte, output kept, output frame_end,
                    output frame_length, output end_cause, input ready);
    modport sink (input valid, input out_byte, input kept, input frame_end,
                  input frame_length, input end_cause, output ready);
endinterface

interface drf_cfg_if import drf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [REG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

// ===== rtl/delimiter_rx_framer.sv =====
// delimiter_rx_framer: cut-through receive framer, counts pending bytes and
// reports frame ends by chunk end, full buffer or delimiter byte
// depends on drf_pkg and drf_ifs
//
//   channel  dir  beat
//   i_byte   in   data_byte, chunk_end
//   o_res    out  out_byte, kept, frame_end, frame_length, end_cause
//   i_cfg    in   reg_index, wdata (always ready)
//
// one beat per clock sustained while o_res is ready; a taken byte passes through:
// input register, then frame logic on the pending counter, then result register
// the pending counter is updated as a beat moves into the result register
// o_res stall holds the result register, then the input register, then i_byte.ready
// synchronous active-low reset: counter zero, registers at their reset values
module delimiter_rx_framer import drf_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    drf_byte_if.sink   i_byte,
    drf_res_if.source  o_res,
    drf_cfg_if.sink    i_cfg
);

    logic [MODE_W-1:0] r_notify_mode;
    logic [BYTE_W-1:0] r_delimiter;
    logic [LEN_W-1:0]  r_buffer_size;
    logic [LEN_W-1:0]  r_pending;
    logic [LEN_W-1:0]  n_pending;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;

    logic    r_out_valid;
    t_result r_out;
    t_result n_out;

    logic             in_advance;
    logic [LEN_W-1:0] eff_size;
    logic [LEN_W-1:0] pend_inc;

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_notify_mode <= MODE_DELIMITER;
            r_delimiter   <= RESET_DELIMITER;
            r_buffer_size <= RESET_BUFFER_SIZE;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.reg_index)
                REG_NOTIFY_MODE:    r_notify_mode <= i_cfg.wdata[MODE_W-1:0];
                REG_DELIMITER_BYTE: r_delimiter   <= i_cfg.wdata[BYTE_W-1:0];
                REG_BUFFER_SIZE:    r_buffer_size <= i_cfg.wdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline handshake
    assign in_advance   = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_byte.ready = !r_in_valid || in_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte <= i_byte.data_byte;
            r_in_last <= i_byte.chunk_end;
        end
    end

    // frame logic
    always_comb begin
        if (r_buffer_size == '0) begin
            eff_size = LEN_W'(1);
        end else if (r_buffer_size > LEN_W'(MAX_BUFFER)) begin
            eff_size = LEN_W'(MAX_BUFFER);
        end else begin
            eff_size = r_buffer_size;
        end
    end

    assign pend_inc = r_pending + LEN_W'(1);

    always_comb begin
        n_out.out_byte     = r_in_byte;
        n_out.kept         = 1'b1;
        n_out.frame_end    = 1'b0;
        n_out.frame_length = '0;
        n_out.end_cause    = CAUSE_DELIMITER;
        n_pending          = pend_inc;
        unique case (r_notify_mode)
            MODE_CHUNK: begin
                if (r_pending >= eff_size) begin
                    n_out.kept = 1'b0;
                    n_pending  = r_pending;
                end
                if (r_in_last) begin
                    n_out.frame_end    = 1'b1;
                    n_out.frame_length = n_pending;
                    n_out.end_cause    = CAUSE_CHUNK;
                    n_pending          = '0;
                end
            end
            MODE_FULL: begin
                if (pend_inc >= eff_size) begin
                    n_out.frame_end    = 1'b1;
                    n_out.frame_length = pend_inc;
                    n_out.end_cause    = CAUSE_FULL;
                    n_pending          = '0;
                end
            end
            default: begin
                if (r_in_byte == r_delimiter) begin
                    n_out.frame_end    = 1'b1;
                    n_out.frame_length = pend_inc;
                    n_out.end_cause    = CAUSE_DELIMITER;
                    n_pending          = '0;
                end else if (pend_inc >= eff_size) begin
                    n_out.frame_end    = 1'b1;
                    n_out.frame_length = pend_inc;
                    n_out.end_cause    = CAUSE_FULL;
                    n_pending          = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (in_advance) begin
            r_pending <= n_pending;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_advance) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.out_byte     = r_out.out_byte;
    assign o_res.kept         = r_out.kept;
    assign o_res.frame_end    = r_out.frame_end;
    assign o_res.frame_length = r_out.frame_length;
    assign o_res.end_cause    = r_out.end_cause;

    // checks
    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= LEN_W'(MAX_BUFFER + 1))
        else $error("pending count beyond buffer limit");

    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.frame_end |->
            r_out.frame_length == '0 && r_out.end_cause == CAUSE_DELIMITER)
        else $error("frame fields set without frame end");

    a_counted_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.frame_end && r_out.end_cause != CAUSE_CHUNK |->
            r_out.frame_length != '0)
        else $error("empty frame ended by delimiter or full buffer");

    a_reset_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_advance && n_out.frame_end |=> r_pending == '0)
        else $error("pending count not cleared after frame end");

endmodule
